FILE: sv/smbt_pkg.sv
// shared types, constants and register codes for the spi master byte engine
`default_nettype none

package smbt_pkg;

    // defaults for the top-level parameters
    localparam int DATA_BITS_DEF   = 8;
    localparam int MAX_DIV_EXP_DEF = 6;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int DIV_EXP_W  = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // largest code the exponent register can hold
    localparam int DIV_EXP_CODE_MAX = (1 << DIV_EXP_W) - 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLK_DIV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE  = 2'd2;

    // register reset values
    localparam logic [DIV_EXP_W-1:0] DIV_EXP_RST   = 3'd1;
    localparam logic                 LSB_FIRST_RST = 1'b0;
    localparam logic [MODE_W-1:0]    SPI_MODE_RST  = 2'd0;

    typedef struct packed {
        logic [DIV_EXP_W-1:0] div_exp;
        logic                 lsb_first;
        logic [MODE_W-1:0]    spi_mode;
    } cfg_t;

    typedef struct packed {
        logic              sck_out;
        logic              mosi_out;
        logic              busy_res;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/smbt_if.sv
// valid/ready channel interfaces for ticks, pin results and register writes
`default_nettype none

interface smbt_tick_if import smbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [BYTE_W-1:0] tx_byte;
    logic              miso_in;

    modport source (output valid, output start_req, output tx_byte, output miso_in,
                    input ready);
    modport sink   (input valid, input start_req, input tx_byte, input miso_in,
                    output ready);
endinterface

interface smbt_pins_if import smbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              sck_out;
    logic              mosi_out;
    logic              busy_res;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output sck_out, output mosi_out, output busy_res,
                    output rx_valid, output rx_byte, input ready);
    modport sink   (input valid, input sck_out, input mosi_out, input busy_res,
                    input rx_valid, input rx_byte, output ready);
endinterface

interface smbt_cfg_if import smbt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/smbt_engine.sv
// spi shift engine: state registers and the per-tick next-state logic
`default_nettype none

module smbt_engine import smbt_pkg::*; #(
    parameter int DATA_BITS           = DATA_BITS_DEF,
    parameter int MAX_DIVIDE_EXPONENT = MAX_DIV_EXP_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire cfg_t              cfg,
    input  wire logic              start_req,
    input  wire logic [BYTE_W-1:0] tx_byte,
    input  wire logic              miso_in,
    output res_t                   res_next
);

    localparam int EXP_TOP = (MAX_DIVIDE_EXPONENT < DIV_EXP_CODE_MAX) ?
                             MAX_DIVIDE_EXPONENT : DIV_EXP_CODE_MAX;
    localparam int CNT_W   = EXP_TOP;
    localparam int BIT_W   = $clog2(DATA_BITS + 1);
    localparam int TOP     = DATA_BITS - 1;

    localparam logic [DIV_EXP_W-1:0] EXP_LIM  = DIV_EXP_W'(EXP_TOP);
    localparam logic [BIT_W-1:0]     LAST_CNT = BIT_W'(DATA_BITS);

    logic [CNT_W-1:0]     hp_cnt_reg, hp_cnt_next;
    logic [BIT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DATA_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [DATA_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic [DATA_BITS-1:0] hold_reg, hold_next;
    logic                 sck_reg, sck_next;
    logic                 active_reg, active_next;

    logic                        cpol, cpha, strobe, cnt_wrap;
    logic [DIV_EXP_W-1:0]        e_eff;
    logic [CNT_W:0]              half;
    logic [DATA_BITS+BYTE_W-1:0] word_wide, hold_wide;
    logic [DATA_BITS-1:0]        word_ext, tx_adv, rx_taken;

    assign cpol = cfg.spi_mode[1];
    assign cpha = cfg.spi_mode[0];

    assign e_eff    = (cfg.div_exp > EXP_LIM) ? EXP_LIM : cfg.div_exp;
    assign half     = (CNT_W+1)'(1) << e_eff;
    assign cnt_wrap = ({1'b0, hp_cnt_reg} + (CNT_W+1)'(1)) >= half;

    assign word_wide = {{DATA_BITS{1'b0}}, tx_byte};
    assign word_ext  = word_wide[DATA_BITS-1:0];

    // vacated bit position fills with ones so the line idles high
    assign tx_adv   = cfg.lsb_first ? {1'b1, tx_shift_reg[TOP:1]}
                                    : {tx_shift_reg[TOP-1:0], 1'b1};
    assign rx_taken = cfg.lsb_first ? {miso_in, rx_shift_reg[TOP:1]}
                                    : {rx_shift_reg[TOP-1:0], miso_in};

    always_comb
    begin
        hp_cnt_next   = hp_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        hold_next     = hold_reg;
        sck_next      = sck_reg;
        active_next   = active_reg;
        strobe        = 1'b0;
        if (!active_reg)
        begin
            sck_next = cpol;
            if (start_req)
            begin
                tx_shift_next = word_ext;
                rx_shift_next = '0;
                bit_cnt_next  = '0;
                hp_cnt_next   = '0;
                active_next   = 1'b1;
            end
        end
        else if (cnt_wrap)
        begin
            hp_cnt_next = '0;
            sck_next    = ~sck_reg;
            if (sck_next != cpol)
            begin
                // leading edge
                if (!cpha)
                    rx_shift_next = rx_taken;
                else if (bit_cnt_reg != '0)
                    tx_shift_next = tx_adv;
            end
            else
            begin
                // trailing edge
                if (cpha)
                    rx_shift_next = rx_taken;
                else
                    tx_shift_next = tx_adv;
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_next >= LAST_CNT)
                begin
                    active_next   = 1'b0;
                    hold_next     = rx_shift_next;
                    tx_shift_next = '1;
                    bit_cnt_next  = '0;
                    strobe        = 1'b1;
                end
            end
        end
        else
        begin
            hp_cnt_next = hp_cnt_reg + CNT_W'(1);
        end
    end

    assign hold_wide = {{BYTE_W{1'b0}}, hold_next};

    always_comb
    begin
        res_next.sck_out  = sck_next;
        res_next.mosi_out = cfg.lsb_first ? tx_shift_next[0] : tx_shift_next[TOP];
        res_next.busy_res = active_next;
        res_next.rx_valid = strobe;
        res_next.rx_byte  = hold_wide[BYTE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_cnt_reg   <= '0;
            bit_cnt_reg  <= '0;
            tx_shift_reg <= '1;
            rx_shift_reg <= '0;
            hold_reg     <= '0;
            sck_reg      <= 1'b0;
            active_reg   <= 1'b0;
        end
        else if (step)
        begin
            hp_cnt_reg   <= hp_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            hold_reg     <= hold_next;
            sck_reg      <= sck_next;
            active_reg   <= active_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/spi_master_byte_transfer_unit.sv
// top level of the spi master byte engine: registers, result register, handshakes
//
//   channel  dir   payload                                       transfer when
//   tick     sink  start_req, tx_byte, miso_in                   valid && ready
//   pins     src   sck_out, mosi_out, busy_res, rx_valid, rx_byte valid && ready
//   cfg      sink  index, data                                   valid && ready
//
// one tick per clock cycle while tick.ready is high; its pin result is registered in the result register
// the next tick is taken in the same cycle as a waiting result is taken
// tick.ready drops only while a result waits and pins.ready is low
// register writes are always taken (cfg.ready is high) and act on the next tick
// rst_n clears the engine to idle and loads the register defaults
`default_nettype none

module spi_master_byte_transfer_unit import smbt_pkg::*; #(
    parameter int DATA_BITS           = DATA_BITS_DEF,
    parameter int MAX_DIVIDE_EXPONENT = MAX_DIV_EXP_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    smbt_tick_if.sink   tick,
    smbt_pins_if.source pins,
    smbt_cfg_if.sink    cfg
);

    cfg_t cfg_reg;
    res_t res_reg;
    res_t res_next;
    logic out_valid_reg;
    logic step;

    assign cfg.ready  = 1'b1;
    assign tick.ready = !out_valid_reg || pins.ready;
    assign step       = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.div_exp   <= DIV_EXP_RST;
            cfg_reg.lsb_first <= LSB_FIRST_RST;
            cfg_reg.spi_mode  <= SPI_MODE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CLK_DIV:   cfg_reg.div_exp   <= cfg.data[DIV_EXP_W-1:0];
                REG_LSB_FIRST: cfg_reg.lsb_first <= cfg.data[0];
                REG_SPI_MODE:  cfg_reg.spi_mode  <= cfg.data[MODE_W-1:0];
                default:       ;
            endcase
        end
    end

    smbt_engine #(
        .DATA_BITS           (DATA_BITS),
        .MAX_DIVIDE_EXPONENT (MAX_DIVIDE_EXPONENT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cfg       (cfg_reg),
        .start_req (tick.start_req),
        .tx_byte   (tick.tx_byte),
        .miso_in   (tick.miso_in),
        .res_next  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (pins.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign pins.valid    = out_valid_reg;
    assign pins.sck_out  = res_reg.sck_out;
    assign pins.mosi_out = res_reg.mosi_out;
    assign pins.busy_res = res_reg.busy_res;
    assign pins.rx_valid = res_reg.rx_valid;
    assign pins.rx_byte  = res_reg.rx_byte;

    // every taken tick shows up as a result on the next cycle
    a_tick_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> pins.valid
    ) else $error("taken tick produced no result");

    // a tick is refused only while an untaken result blocks the register
    a_ready_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        !tick.ready |-> pins.valid && !pins.ready
    ) else $error("tick refused without a waiting result");

    // the completion strobe is shown on an idle result
    a_strobe_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        pins.valid && pins.rx_valid |-> !pins.busy_res
    ) else $error("receive strobe while still busy");

    // mosi rests high between transfers
    a_mosi_idle_high: assert property (
        @(posedge clk) disable iff (!rst_n)
        pins.valid && !pins.busy_res |-> pins.mosi_out
    ) else $error("mosi low while idle");

endmodule

`default_nettype wire
